/* sv/tph_pkg.sv */
`timescale 1ns / 1ps

package tph_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int IDX_W   = 10;
    localparam int CFG_W   = 11;
    localparam int COUNT_W = 11;
    localparam int TOTAL_W = 21;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(1024);
    localparam logic [TOTAL_W-1:0] TOTAL_LIMIT = TOTAL_W'(1048576);
    localparam logic [7:0]         HIT_MASK    = 8'hf8;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic KIND_ROW = 1'b0;
    localparam logic KIND_COL = 1'b1;

    localparam logic [1:0] CFG_FRAME_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_CENTER_COLUMN = 2'd2;
    localparam logic [1:0] CFG_CENTER_ROW    = 2'd3;

    // one accepted item as it leaves the front stage
    typedef struct packed {
        logic               is_read;
        logic [COL_W-1:0]   addr;
        logic               row0;
        logic               hit;
        logic               has_res;
        logic [IDX_W-1:0]   index;
        logic [COUNT_W-1:0] count;
        logic               frame_done;
        logic [TOTAL_W-1:0] quad_left;
        logic [TOTAL_W-1:0] quad_right;
        logic [TOTAL_W-1:0] total_hits;
    } t_item;

    typedef struct packed {
        logic               en;
        logic [COL_W-1:0]   addr;
        logic [COUNT_W-1:0] data;
    } t_wr;

    function automatic logic [COUNT_W-1:0] sat_count(input logic [COUNT_W-1:0] v);
        return (v < COUNT_LIMIT) ? v + COUNT_W'(1) : COUNT_LIMIT;
    endfunction

    function automatic logic [TOTAL_W-1:0] sat_total(input logic [TOTAL_W-1:0] v);
        return (v < TOTAL_LIMIT) ? v + TOTAL_W'(1) : TOTAL_LIMIT;
    endfunction

    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] maxv);
        if (v == '0) begin
            return CFG_W'(1);
        end
        return (v > maxv) ? maxv : v;
    endfunction

endpackage

/* sv/tph_colmem.sv */
`timescale 1ns / 1ps

module tph_colmem (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [tph_pkg::COL_W-1:0]    i_rd_addr,
    output logic [tph_pkg::COUNT_W-1:0]  o_rd_data,
    input  tph_pkg::t_wr                 i_wr
);

    logic [tph_pkg::COUNT_W-1:0] mem [tph_pkg::MAX_WIDTH];
    logic [tph_pkg::COUNT_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/tph_front.sv */
`timescale 1ns / 1ps

module tph_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [1:0]                  i_cfg_index,
    input  logic [tph_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                        i_accept,
    input  logic                        i_operation,
    input  logic [7:0]                  i_pixel,
    input  logic [tph_pkg::IDX_W-1:0]   i_column_index,
    output tph_pkg::t_item              o_item
);

    localparam logic [tph_pkg::CFG_W-1:0] WMAX = tph_pkg::CFG_W'(tph_pkg::MAX_WIDTH);
    localparam logic [tph_pkg::CFG_W-1:0] HMAX = tph_pkg::CFG_W'(tph_pkg::MAX_HEIGHT);

    logic [tph_pkg::CFG_W-1:0]   r_frame_width, r_frame_height;
    logic [tph_pkg::CFG_W-1:0]   r_center_column, r_center_row;
    logic [tph_pkg::COL_W-1:0]   r_col_pos;
    logic [tph_pkg::ROW_W-1:0]   r_row_pos;
    logic [tph_pkg::COUNT_W-1:0] r_row_hits, n_row_hits;
    logic [tph_pkg::TOTAL_W-1:0] r_left, n_left, r_right, n_right, r_total, n_total;

    logic                        hit, row_end, frame_end, in_quad, is_left, pix_acc;
    logic [tph_pkg::CFG_W-1:0]   w_eff, h_eff;
    logic [tph_pkg::CFG_W-1:0]   col_ext, row_ext;

    always_comb begin
        hit     = (i_pixel & tph_pkg::HIT_MASK) != 8'h00;
        w_eff   = tph_pkg::clamp_size(r_frame_width, WMAX);
        h_eff   = tph_pkg::clamp_size(r_frame_height, HMAX);
        col_ext = tph_pkg::CFG_W'(r_col_pos);
        row_ext = tph_pkg::CFG_W'(r_row_pos);
        // col/row positions never reach 2^CFG_W - 1, so +1 cannot wrap
        row_end   = (col_ext + tph_pkg::CFG_W'(1)) >= w_eff;
        frame_end = (row_ext + tph_pkg::CFG_W'(1)) >= h_eff;
        in_quad   = row_ext < r_center_row;
        is_left   = col_ext < r_center_column;

        n_row_hits = hit ? tph_pkg::sat_count(r_row_hits) : r_row_hits;
        n_total    = hit ? tph_pkg::sat_total(r_total) : r_total;
        n_left     = (hit && in_quad && is_left) ? tph_pkg::sat_total(r_left) : r_left;
        n_right    = (hit && in_quad && !is_left) ? tph_pkg::sat_total(r_right) : r_right;
        pix_acc    = i_accept && (i_operation == tph_pkg::OP_PIXEL);
    end

    always_comb begin
        o_item.is_read    = (i_operation == tph_pkg::OP_READ);
        o_item.addr       = o_item.is_read ? tph_pkg::COL_W'(i_column_index) : r_col_pos;
        o_item.row0       = (r_row_pos == '0);
        o_item.hit        = hit;
        o_item.has_res    = o_item.is_read || row_end;
        o_item.index      = tph_pkg::IDX_W'(r_row_pos);
        o_item.count      = n_row_hits;
        o_item.frame_done = frame_end;
        o_item.quad_left  = frame_end ? n_left  : '0;
        o_item.quad_right = frame_end ? n_right : '0;
        o_item.total_hits = frame_end ? n_total : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= tph_pkg::CFG_W'(640);
            r_frame_height  <= tph_pkg::CFG_W'(480);
            r_center_column <= '0;
            r_center_row    <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                tph_pkg::CFG_FRAME_WIDTH:   r_frame_width   <= i_cfg_wdata;
                tph_pkg::CFG_FRAME_HEIGHT:  r_frame_height  <= i_cfg_wdata;
                tph_pkg::CFG_CENTER_COLUMN: r_center_column <= i_cfg_wdata;
                tph_pkg::CFG_CENTER_ROW:    r_center_row    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos  <= '0;
            r_row_pos  <= '0;
            r_row_hits <= '0;
            r_left     <= '0;
            r_right    <= '0;
            r_total    <= '0;
        end else if (pix_acc) begin
            if (!row_end) begin
                r_col_pos  <= r_col_pos + tph_pkg::COL_W'(1);
                r_row_hits <= n_row_hits;
                r_left     <= n_left;
                r_right    <= n_right;
                r_total    <= n_total;
            end else begin
                r_col_pos  <= '0;
                r_row_hits <= '0;
                if (frame_end) begin
                    r_row_pos <= '0;
                    r_left    <= '0;
                    r_right   <= '0;
                    r_total   <= '0;
                end else begin
                    r_row_pos <= r_row_pos + tph_pkg::ROW_W'(1);
                    r_left    <= n_left;
                    r_right   <= n_right;
                    r_total   <= n_total;
                end
            end
        end
    end

endmodule

/* sv/tph_back.sv */
`timescale 1ns / 1ps

module tph_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  tph_pkg::t_item                i_item,
    output logic                          o_in_ready,
    input  logic [tph_pkg::COUNT_W-1:0]   i_rd_data,
    output tph_pkg::t_wr                  o_wr,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_kind,
    output logic [tph_pkg::IDX_W-1:0]     o_index,
    output logic [tph_pkg::COUNT_W-1:0]   o_count,
    output logic                          o_frame_done,
    output logic [tph_pkg::TOTAL_W-1:0]   o_quad_left,
    output logic [tph_pkg::TOTAL_W-1:0]   o_quad_right,
    output logic [tph_pkg::TOTAL_W-1:0]   o_total_hits
);

    logic                        r_s1_valid;
    tph_pkg::t_item              r_s1;
    tph_pkg::t_wr                r_fwd;
    logic                        r_out_valid;
    logic                        r_kind, r_frame_done;
    logic [tph_pkg::IDX_W-1:0]   r_index;
    logic [tph_pkg::COUNT_W-1:0] r_count;
    logic [tph_pkg::TOTAL_W-1:0] r_quad_left, r_quad_right, r_total_hits;

    logic                        out_free, s1_go, s1_emit;
    logic [tph_pkg::COUNT_W-1:0] old_val;

    always_comb begin
        // the write that landed on the same edge as our read is not in i_rd_data
        old_val  = (r_fwd.en && (r_fwd.addr == r_s1.addr)) ? r_fwd.data : i_rd_data;
        out_free = !r_out_valid || i_out_ready;
        s1_go    = r_s1_valid && (!r_s1.has_res || out_free);
        s1_emit  = s1_go && r_s1.has_res;
        o_in_ready = !r_s1_valid || s1_go;

        o_wr.en   = s1_go && !r_s1.is_read && (r_s1.row0 || r_s1.hit);
        o_wr.addr = r_s1.addr;
        o_wr.data = r_s1.row0 ? tph_pkg::COUNT_W'(r_s1.hit) : tph_pkg::sat_count(old_val);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd.en   <= 1'b0;
        end else begin
            if (i_accept) begin
                r_s1_valid <= 1'b1;
                r_fwd      <= o_wr;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1 <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_emit) begin
            if (r_s1.is_read) begin
                r_kind       <= tph_pkg::KIND_COL;
                r_index      <= tph_pkg::IDX_W'(r_s1.addr);
                r_count      <= old_val;
                r_frame_done <= 1'b0;
                r_quad_left  <= '0;
                r_quad_right <= '0;
                r_total_hits <= '0;
            end else begin
                r_kind       <= tph_pkg::KIND_ROW;
                r_index      <= r_s1.index;
                r_count      <= r_s1.count;
                r_frame_done <= r_s1.frame_done;
                r_quad_left  <= r_s1.quad_left;
                r_quad_right <= r_s1.quad_right;
                r_total_hits <= r_s1.total_hits;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_index      = r_index;
    assign o_count      = r_count;
    assign o_frame_done = r_frame_done;
    assign o_quad_left  = r_quad_left;
    assign o_quad_right = r_quad_right;
    assign o_total_hits = r_total_hits;

endmodule

/* sv/thresholded_projection_histogram_core.sv */
`timescale 1ns / 1ps
// Channel   Handshake                   Payload
// config    i_cfg_wr_en (no wait)       i_cfg_index, i_cfg_wdata
// input     i_in_valid / o_in_ready     i_operation, i_pixel, i_column_index
// output    o_out_valid / i_out_ready   o_kind, o_index, o_count, o_frame_done,
//                                       o_quad_left, o_quad_right, o_total_hits
//
// One item per clock while o_in_ready is high. The input beat's edge reads the
// column store and loads the stage register; the output register then raises
// o_out_valid; a one-entry bypass covers a write on the same edge as the read.
// Synchronous active-low reset clears positions, counters and valids; the
// column store is not cleared.
// A stalled output holds one result; the stage behind it keeps taking beats
// that give no result, takes one more that does, then holds o_in_ready low.

module thresholded_projection_histogram_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [1:0]                    i_cfg_index,
    input  logic [tph_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_operation,
    input  logic [7:0]                    i_pixel,
    input  logic [tph_pkg::IDX_W-1:0]     i_column_index,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_kind,
    output logic [tph_pkg::IDX_W-1:0]     o_index,
    output logic [tph_pkg::COUNT_W-1:0]   o_count,
    output logic                          o_frame_done,
    output logic [tph_pkg::TOTAL_W-1:0]   o_quad_left,
    output logic [tph_pkg::TOTAL_W-1:0]   o_quad_right,
    output logic [tph_pkg::TOTAL_W-1:0]   o_total_hits
);

    logic                        accept;
    tph_pkg::t_item              item;
    tph_pkg::t_wr                wr;
    logic [tph_pkg::COUNT_W-1:0] rd_data;

    assign accept = i_in_valid && o_in_ready;

    tph_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_accept       (accept),
        .i_operation    (i_operation),
        .i_pixel        (i_pixel),
        .i_column_index (i_column_index),
        .o_item         (item)
    );

    tph_colmem u_colmem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (item.addr),
        .o_rd_data (rd_data),
        .i_wr      (wr)
    );

    tph_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_item       (item),
        .o_in_ready   (o_in_ready),
        .i_rd_data    (rd_data),
        .o_wr         (wr),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kind       (o_kind),
        .o_index      (o_index),
        .o_count      (o_count),
        .o_frame_done (o_frame_done),
        .o_quad_left  (o_quad_left),
        .o_quad_right (o_quad_right),
        .o_total_hits (o_total_hits)
    );

endmodule

/* sv/tph_checker.sv */
`timescale 1ns / 1ps

module tph_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  logic                          o_kind,
    input  logic [tph_pkg::IDX_W-1:0]     o_index,
    input  logic                          o_frame_done,
    input  logic [tph_pkg::TOTAL_W-1:0]   o_quad_left,
    input  logic [tph_pkg::TOTAL_W-1:0]   o_quad_right,
    input  logic [tph_pkg::TOTAL_W-1:0]   o_total_hits
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_index) && $stable(o_kind))
        else $error("output beat changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_read_no_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == tph_pkg::KIND_COL) |->
            !o_frame_done && (o_quad_left == '0) && (o_quad_right == '0)
            && (o_total_hits == '0))
        else $error("column read beat carries frame totals");

    a_totals_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_frame_done |->
            (o_quad_left == '0) && (o_quad_right == '0) && (o_total_hits == '0))
        else $error("totals shown before frame end");

    a_quads_in_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_done |->
            (o_quad_left <= o_total_hits) && (o_quad_right <= o_total_hits))
        else $error("quadrant count above frame total");

endmodule

bind thresholded_projection_histogram_core tph_checker u_tph_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_kind       (o_kind),
    .o_index      (o_index),
    .o_frame_done (o_frame_done),
    .o_quad_left  (o_quad_left),
    .o_quad_right (o_quad_right),
    .o_total_hits (o_total_hits)
);

/* verif/tb_thresholded_projection_histogram_core.sv */
`timescale 1ns / 1ps

module tb_thresholded_projection_histogram_core;

    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 5;
    localparam int RUN_BEATS = 820;
    localparam logic [7:0] CORNER_PX [12] = '{8'h00, 8'h07, 8'h08, 8'hff, 8'hf8, 8'h80,
                                              8'h01, 8'h10, 8'h7f, 8'h40, 8'h20, 8'h00};

    typedef struct packed {
        logic                        kind;
        logic [tph_pkg::IDX_W-1:0]   index;
        logic [tph_pkg::COUNT_W-1:0] count;
        logic                        frame_done;
        logic [tph_pkg::TOTAL_W-1:0] quad_left;
        logic [tph_pkg::TOTAL_W-1:0] quad_right;
        logic [tph_pkg::TOTAL_W-1:0] total_hits;
    } t_proj_result;

    // Tracks frame position, counters and the column store; queues the results
    // that column reads and row-ending beats must produce.
    class projection_scoreboard;
        int unsigned width_reg, height_reg, ccol_reg, crow_reg;
        int unsigned col_pos, row_pos, row_hits;
        int unsigned left_hits, right_hits, frame_hits;
        int unsigned column_hits [tph_pkg::MAX_WIDTH];
        int unsigned written_hi;   // columns [0, written_hi) hold defined counts
        t_proj_result expected_q [$];
        int mismatches, beats, reads, rows, frames;

        function new();
            width_reg = 640;
            height_reg = 480;
            ccol_reg = 0;
            crow_reg = 0;
            col_pos = 0;
            row_pos = 0;
            row_hits = 0;
            left_hits = 0;
            right_hits = 0;
            frame_hits = 0;
            written_hi = 0;
            mismatches = 0;
            beats = 0;
            reads = 0;
            rows = 0;
            frames = 0;
        endfunction

        function int unsigned fit_size(int unsigned v, int unsigned maxv);
            if (v == 0) begin
                return 1;
            end
            return (v > maxv) ? maxv : v;
        endfunction

        function void set_reg(logic [1:0] idx, int unsigned v);
            case (idx)
                tph_pkg::CFG_FRAME_WIDTH:   width_reg = v;
                tph_pkg::CFG_FRAME_HEIGHT:  height_reg = v;
                tph_pkg::CFG_CENTER_COLUMN: ccol_reg = v;
                tph_pkg::CFG_CENTER_ROW:    crow_reg = v;
                default: ;
            endcase
        endfunction

        function void note_beat(logic op, logic [7:0] px, logic [tph_pkg::IDX_W-1:0] ci);
            t_proj_result res;
            int unsigned w, h;
            bit hit, last_row;
            beats++;
            res = '0;
            if (op == tph_pkg::OP_READ) begin
                reads++;
                res.kind = tph_pkg::KIND_COL;
                res.index = ci;
                res.count = (ci < tph_pkg::MAX_WIDTH) ?
                            tph_pkg::COUNT_W'(column_hits[ci]) : '0;
                expected_q.push_back(res);
                return;
            end
            w = fit_size(width_reg, tph_pkg::MAX_WIDTH);
            h = fit_size(height_reg, tph_pkg::MAX_HEIGHT);
            hit = (px & tph_pkg::HIT_MASK) != 0;
            if (row_pos == 0) begin
                column_hits[col_pos] = hit;
                if (col_pos + 1 > written_hi) begin
                    written_hi = col_pos + 1;
                end
            end else if (hit && column_hits[col_pos] < tph_pkg::COUNT_LIMIT) begin
                column_hits[col_pos]++;
            end
            if (hit) begin
                if (row_hits < tph_pkg::COUNT_LIMIT) row_hits++;
                if (frame_hits < tph_pkg::TOTAL_LIMIT) frame_hits++;
                if (row_pos < crow_reg) begin
                    if (col_pos < ccol_reg) begin
                        if (left_hits < tph_pkg::TOTAL_LIMIT) left_hits++;
                    end else begin
                        if (right_hits < tph_pkg::TOTAL_LIMIT) right_hits++;
                    end
                end
            end
            if (col_pos + 1 < w) begin
                col_pos++;
                return;
            end
            last_row = (row_pos + 1 >= h);
            rows++;
            res.kind = tph_pkg::KIND_ROW;
            res.index = tph_pkg::IDX_W'(row_pos);
            res.count = tph_pkg::COUNT_W'(row_hits);
            res.frame_done = last_row;
            if (last_row) begin
                frames++;
                res.quad_left = tph_pkg::TOTAL_W'(left_hits);
                res.quad_right = tph_pkg::TOTAL_W'(right_hits);
                res.total_hits = tph_pkg::TOTAL_W'(frame_hits);
                row_pos = 0;
                left_hits = 0;
                right_hits = 0;
                frame_hits = 0;
            end else begin
                row_pos++;
            end
            col_pos = 0;
            row_hits = 0;
            expected_q.push_back(res);
        endfunction

        function void check_beat(t_proj_result got);
            t_proj_result want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: result with nothing expected: kind=%0d index=%0d count=%0d",
                             got.kind, got.index, got.count);
                end
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: exp kind=%0d index=%0d count=%0d done=%0d L=%0d R=%0d T=%0d",
                             want.kind, want.index, want.count, want.frame_done,
                             want.quad_left, want.quad_right, want.total_hits);
                    $display("       got kind=%0d index=%0d count=%0d done=%0d L=%0d R=%0d T=%0d",
                             got.kind, got.index, got.count, got.frame_done,
                             got.quad_left, got.quad_right, got.total_hits);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_wr_en;
    logic [1:0]                  cfg_index;
    logic [tph_pkg::CFG_W-1:0]   cfg_wdata;
    logic                        in_valid;
    logic                        in_ready;
    logic                        in_op;
    logic [7:0]                  in_pixel;
    logic [tph_pkg::IDX_W-1:0]   in_col;
    logic                        out_valid;
    logic                        out_ready;
    logic                        out_kind;
    logic [tph_pkg::IDX_W-1:0]   out_index;
    logic [tph_pkg::COUNT_W-1:0] out_count;
    logic                        out_frame_done;
    logic [tph_pkg::TOTAL_W-1:0] out_quad_left;
    logic [tph_pkg::TOTAL_W-1:0] out_quad_right;
    logic [tph_pkg::TOTAL_W-1:0] out_total_hits;

    projection_scoreboard sb = new();
    bit src_calm;
    bit sink_calm;
    int sink_hold;
    int quiet_cycles;
    int cfg_writes;

    thresholded_projection_histogram_core u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_operation    (in_op),
        .i_pixel        (in_pixel),
        .i_column_index (in_col),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_kind         (out_kind),
        .o_index        (out_index),
        .o_count        (out_count),
        .o_frame_done   (out_frame_done),
        .o_quad_left    (out_quad_left),
        .o_quad_right   (out_quad_right),
        .o_total_hits   (out_total_hits)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int draw_gap(bit calm);
        return calm ? 0 : int'($urandom_range(0, 13));
    endfunction

    function automatic logic [7:0] rand_pixel();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return 8'($urandom_range(8, 255));
        if (r < 8) return 8'($urandom_range(0, 7));
        return 8'($urandom_range(0, 255));
    endfunction

    // Beat monitor, checker and watchdog
    always @(posedge clk) begin
        t_proj_result got;
        bit moved;
        moved = 1'b0;
        if (rst_n && out_valid && out_ready) begin
            got = '{out_kind, out_index, out_count, out_frame_done,
                    out_quad_left, out_quad_right, out_total_hits};
            sb.check_beat(got);
            sink_hold = draw_gap(sink_calm);
            moved = 1'b1;
        end
        if (rst_n && in_valid && in_ready) begin
            sb.note_beat(in_op, in_pixel, in_col);
            moved = 1'b1;
        end
        if (moved || !rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_thresholded_projection_histogram_core failed");
            $finish;
        end
    end

    // Result side: ready drops for a drawn number of cycles after each beat
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (sink_hold > 0) begin
                out_ready <= 1'b0;
                sink_hold--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input int unsigned v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= tph_pkg::CFG_W'(v);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_reg(idx, v & 32'h7ff);
        cfg_writes++;
        @(negedge clk);
    endtask

    task automatic send_beat(input logic op, input logic [7:0] px,
                             input logic [tph_pkg::IDX_W-1:0] ci);
        int gap;
        gap = draw_gap(src_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_op <= op;
        in_pixel <= px;
        in_col <= ci;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_pixel(input logic [7:0] px);
        send_beat(tph_pkg::OP_PIXEL, px, tph_pkg::IDX_W'($urandom_range(0, 1023)));
    endtask

    // reads only ever target columns already written since reset
    task automatic send_mixed();
        if (sb.written_hi > 0 && $urandom_range(0, 6) == 0) begin
            send_beat(tph_pkg::OP_READ, 8'($urandom_range(0, 255)),
                      tph_pkg::IDX_W'($urandom_range(0, sb.written_hi - 1)));
        end else begin
            send_pixel(rand_pixel());
        end
    endtask

    // drop valid, wait out every expected result plus the pipeline tail
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // 1x1 frame: one pixel returns the position to row 0, column 0
    task automatic restart_frame();
        settle();
        write_reg(tph_pkg::CFG_FRAME_WIDTH, 1);
        write_reg(tph_pkg::CFG_FRAME_HEIGHT, 1);
        send_pixel(rand_pixel());
        settle();
    endtask

    initial begin
        int phase_no;
        int unsigned wv, hv, cc, cr;
        int n;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = tph_pkg::CFG_FRAME_WIDTH;
        cfg_wdata = '0;
        in_valid = 1'b0;
        in_op = tph_pkg::OP_PIXEL;
        in_pixel = '0;
        in_col = '0;
        src_calm = 1'b0;
        sink_calm = 1'b0;
        sink_hold = 0;
        quiet_cycles = 0;
        cfg_writes = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // small frame with the hit threshold corners, quadrant split in the middle
        write_reg(tph_pkg::CFG_FRAME_WIDTH, 4);
        write_reg(tph_pkg::CFG_FRAME_HEIGHT, 3);
        write_reg(tph_pkg::CFG_CENTER_COLUMN, 2);
        write_reg(tph_pkg::CFG_CENTER_ROW, 2);
        for (int i = 0; i < 12; i++) begin
            send_beat(tph_pkg::OP_PIXEL, CORNER_PX[i],
                      (i % 2 == 0) ? tph_pkg::IDX_W'(0) : tph_pkg::IDX_W'(1023));
        end
        send_beat(tph_pkg::OP_READ, 8'hff, tph_pkg::IDX_W'(0));
        send_beat(tph_pkg::OP_READ, 8'h00, tph_pkg::IDX_W'(3));
        // zero sizes behave as 1x1
        settle();
        write_reg(tph_pkg::CFG_FRAME_WIDTH, 0);
        write_reg(tph_pkg::CFG_FRAME_HEIGHT, 0);
        send_pixel(8'hff);
        send_pixel(8'h00);
        // centres past the frame: every column left, every row counted
        settle();
        write_reg(tph_pkg::CFG_FRAME_WIDTH, 3);
        write_reg(tph_pkg::CFG_FRAME_HEIGHT, 2);
        write_reg(tph_pkg::CFG_CENTER_COLUMN, 1024);
        write_reg(tph_pkg::CFG_CENTER_ROW, 1024);
        for (int i = 0; i < 6; i++) begin
            send_pixel(8'(8 * i + 1));
        end
        send_beat(tph_pkg::OP_READ, 8'h5a, tph_pkg::IDX_W'(2));

        phase_no = 0;
        while (sb.beats < RUN_BEATS) begin
            phase_no++;
            src_calm = ($urandom_range(0, 3) == 0);
            sink_calm = ($urandom_range(0, 3) == 0);
            if (phase_no == 4) begin
                // widest row, then shrunk mid-row so it ends at the next pixel
                restart_frame();
                write_reg(tph_pkg::CFG_FRAME_WIDTH, 1024);
                write_reg(tph_pkg::CFG_FRAME_HEIGHT, 2);
                write_reg(tph_pkg::CFG_CENTER_COLUMN, 512);
                write_reg(tph_pkg::CFG_CENTER_ROW, 1);
                repeat (30) send_pixel(rand_pixel());
                settle();
                write_reg(tph_pkg::CFG_FRAME_WIDTH, 0);
                repeat (12) send_mixed();
            end else if (phase_no == 9) begin
                // tall frame, height dropped mid-frame to force a frame end
                restart_frame();
                write_reg(tph_pkg::CFG_FRAME_HEIGHT, 2047);
                write_reg(tph_pkg::CFG_CENTER_COLUMN, 0);
                write_reg(tph_pkg::CFG_CENTER_ROW, 2047);
                repeat (40) send_pixel(rand_pixel());
                settle();
                write_reg(tph_pkg::CFG_FRAME_HEIGHT, 0);
                repeat (8) send_mixed();
            end else begin
                settle();
                if ($urandom_range(0, 1) == 0) begin
                    case ($urandom_range(0, 19))
                        0: wv = 0;
                        1: wv = 2047;
                        2: wv = 1024;
                        3, 4, 5: wv = $urandom_range(13, 40);
                        default: wv = $urandom_range(1, 12);
                    endcase
                    // past row 0 the row may not reach columns never written
                    if (sb.row_pos != 0 &&
                        sb.fit_size(wv, tph_pkg::MAX_WIDTH) > sb.written_hi) begin
                        wv = sb.written_hi;
                    end
                    write_reg(tph_pkg::CFG_FRAME_WIDTH, wv);
                end
                if ($urandom_range(0, 1) == 0) begin
                    case ($urandom_range(0, 19))
                        0: hv = 0;
                        1: hv = 2047;
                        2: hv = 1024;
                        default: hv = $urandom_range(1, 6);
                    endcase
                    write_reg(tph_pkg::CFG_FRAME_HEIGHT, hv);
                end
                if ($urandom_range(0, 1) == 0) begin
                    case ($urandom_range(0, 9))
                        0: cc = 0;
                        1: cc = 2047;
                        2: cc = 1024;
                        default: cc = $urandom_range(0,
                                     sb.fit_size(sb.width_reg, tph_pkg::MAX_WIDTH) + 1);
                    endcase
                    write_reg(tph_pkg::CFG_CENTER_COLUMN, cc);
                end
                if ($urandom_range(0, 1) == 0) begin
                    case ($urandom_range(0, 9))
                        0: cr = 0;
                        1: cr = 2047;
                        2: cr = 1024;
                        default: cr = $urandom_range(0,
                                     sb.fit_size(sb.height_reg, tph_pkg::MAX_HEIGHT) + 1);
                    endcase
                    write_reg(tph_pkg::CFG_CENTER_ROW, cr);
                end
                n = $urandom_range(20, 60);
                repeat (n) send_mixed();
            end
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        $display("Run: %0d beats in (%0d column reads), %0d row results, %0d frames closed",
                 sb.beats, sb.reads, sb.rows, sb.frames);
        $display("     %0d register writes over %0d phases, %0d mismatches",
                 cfg_writes, phase_no, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb_thresholded_projection_histogram_core passed");
        end else begin
            $display("tb_thresholded_projection_histogram_core failed");
        end
        $finish;
    end

endmodule

/* thresholded_projection_histogram_core.f */
sv/tph_pkg.sv
sv/tph_colmem.sv
sv/tph_front.sv
sv/tph_back.sv
sv/thresholded_projection_histogram_core.sv
sv/tph_checker.sv
verif/tb_thresholded_projection_histogram_core.sv
